// ===== rtl/input_event_report_queue_macros.svh =====
// ----------------------------------------------------------------------------
// input_event_report_queue_macros.svh
// Assertion helpers for the input event report queue checker.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_REPORT_QUEUE_MACROS_SVH
`define INPUT_EVENT_REPORT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define IEPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define IEPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/iepq_pkg.sv =====
// ----------------------------------------------------------------------------
// iepq_pkg
// Shared types and constants of the input event report queue.
// ----------------------------------------------------------------------------
package iepq_pkg;

	// Default ring depths
	localparam int KEY_DEPTH_DEF = 64;
	localparam int PTR_DEPTH_DEF = 64;

	// Stream widths
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 1;

	// Event types and codes
	localparam logic [15:0] EVT_SYNC      = 16'd0;
	localparam logic [15:0] EVT_KEY       = 16'd1;
	localparam logic [15:0] EVT_ABS       = 16'd3;
	localparam logic [15:0] AXIS_X        = 16'd0;
	localparam logic [15:0] AXIS_Y        = 16'd1;
	localparam logic [15:0] SYNC_REPORT   = 16'd0;
	localparam logic [15:0] BUTTON_LEFT   = 16'd272;
	localparam logic [15:0] BUTTON_RIGHT  = 16'd273;
	localparam logic [15:0] BUTTON_MIDDLE = 16'd274;

	// Button bit positions in the latched button word
	localparam int BTN_LEFT   = 0;
	localparam int BTN_RIGHT  = 1;
	localparam int BTN_MIDDLE = 2;

	// Request kind carried in s_axis_tuser
	typedef enum logic [1:0] {
		ACT_KEY_EVT    = 2'd0,
		ACT_TABLET_EVT = 2'd1,
		ACT_POP_KEY    = 2'd2,
		ACT_POP_PTR    = 2'd3
	} action_t;

	// What the result stage has to show
	typedef enum logic [1:0] {
		RES_NONE,
		RES_KEY,
		RES_PTR
	} res_kind_t;

	// Result word, key_code in the lowest bits
	typedef struct packed {
		logic        pending;
		logic        middle_down;
		logic        right_down;
		logic        left_down;
		logic [31:0] ptr_y;
		logic [31:0] ptr_x;
		logic        key_pressed;
		logic [8:0]  key_code;
	} result_t;

	localparam int RES_W = $bits(result_t);

endpackage

// ===== rtl/input_event_report_queue.sv =====
// ----------------------------------------------------------------------------
// input_event_report_queue
// Keyboard key ring and tablet pointer report ring with pop requests.
// ----------------------------------------------------------------------------
// Takes one item per cycle when the output side keeps up; every item gives
// exactly one result, which passes from the registered read port of the ring
// memories through the output register. Key events below the first
// mouse-button code go to the key ring; tablet axis/button events update the
// latched pointer state and a sync report pushes a snapshot into the pointer
// ring. Each ring keeps one entry less than its depth and drops new entries
// when full. Pops of an empty ring return valid_res 0. Rings need no clearing
// after reset.
// ----------------------------------------------------------------------------
module input_event_report_queue #(
	parameter int KEY_DEPTH     = iepq_pkg::KEY_DEPTH_DEF,
	parameter int POINTER_DEPTH = iepq_pkg::PTR_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// ev_type[15:0], ev_code[31:16], ev_value[63:32]
	input  logic [iepq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [iepq_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// key_code[8:0], key_pressed[9], ptr_x[41:10], ptr_y[73:42], left_down[74],
	// right_down[75], middle_down[76], pending[77], zero[79:78]
	output logic [iepq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// valid_res[0]
	output logic [iepq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	localparam int KAW = $clog2(KEY_DEPTH);
	localparam int PAW = $clog2(POINTER_DEPTH);
	localparam logic [KAW-1:0] KEY_LAST = KAW'(KEY_DEPTH - 1);
	localparam logic [PAW-1:0] PTR_LAST = PAW'(POINTER_DEPTH - 1);
	localparam int KEY_ENTRY_W = 10;
	localparam int PTR_ENTRY_W = 67;

	// Ring memories
	logic [KEY_ENTRY_W-1:0] key_mem [KEY_DEPTH];
	logic [PTR_ENTRY_W-1:0] ptr_mem [POINTER_DEPTH];

	// Control state
	logic [KAW-1:0] key_head_q, key_tail_q;
	logic [PAW-1:0] ptr_head_q, ptr_tail_q;
	logic [31:0]    latched_x_q, latched_y_q;
	logic [2:0]     latched_btn_q;

	// Read data and pipeline
	logic [KEY_ENTRY_W-1:0] key_rd_q;
	logic [PTR_ENTRY_W-1:0] ptr_rd_q;
	logic                   valid_s1;
	iepq_pkg::res_kind_t    kind_s1;
	logic                   pending_s1;
	logic                   out_valid_q;
	iepq_pkg::result_t      out_res_q;
	logic                   out_vres_q;

	// Decode
	logic                in_fire, s1_adv;
	iepq_pkg::action_t   action;
	logic [15:0]         ev_type, ev_code;
	logic [31:0]         ev_value;
	logic                ev_nz;
	logic [KAW-1:0]      key_tail_nxt, key_head_nxt, key_tail_inc, key_head_inc;
	logic [PAW-1:0]      ptr_tail_nxt, ptr_head_nxt, ptr_tail_inc, ptr_head_inc;
	logic                key_push, key_pop, ptr_push, ptr_pop;
	logic                set_x, set_y;
	logic [2:0]          btn_nxt;
	iepq_pkg::res_kind_t kind_nxt;
	logic                pending_nxt;
	iepq_pkg::result_t   res_nxt;

	assign action   = iepq_pkg::action_t'(s_axis_tuser);
	assign ev_type  = s_axis_tdata[15:0];
	assign ev_code  = s_axis_tdata[31:16];
	assign ev_value = s_axis_tdata[63:32];
	assign ev_nz    = (ev_value != 32'd0);

	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Wrapping increments
	assign key_tail_inc = (key_tail_q == KEY_LAST) ? '0 : key_tail_q + 1'b1;
	assign key_head_inc = (key_head_q == KEY_LAST) ? '0 : key_head_q + 1'b1;
	assign ptr_tail_inc = (ptr_tail_q == PTR_LAST) ? '0 : ptr_tail_q + 1'b1;
	assign ptr_head_inc = (ptr_head_q == PTR_LAST) ? '0 : ptr_head_q + 1'b1;

	// Request decode and latch updates
	always_comb begin
		key_push = 1'b0;
		key_pop  = 1'b0;
		ptr_push = 1'b0;
		ptr_pop  = 1'b0;
		set_x    = 1'b0;
		set_y    = 1'b0;
		btn_nxt  = latched_btn_q;
		kind_nxt = iepq_pkg::RES_NONE;
		if (in_fire) begin
			case (action)
				iepq_pkg::ACT_KEY_EVT: begin
					key_push = (ev_type == iepq_pkg::EVT_KEY) &&
						(ev_code < iepq_pkg::BUTTON_LEFT) && (key_tail_inc != key_head_q);
				end
				iepq_pkg::ACT_TABLET_EVT: begin
					if (ev_type == iepq_pkg::EVT_ABS) begin
						set_x = (ev_code == iepq_pkg::AXIS_X);
						set_y = (ev_code == iepq_pkg::AXIS_Y);
					end else if (ev_type == iepq_pkg::EVT_KEY) begin
						if (ev_code == iepq_pkg::BUTTON_LEFT)
							btn_nxt[iepq_pkg::BTN_LEFT] = ev_nz;
						else if (ev_code == iepq_pkg::BUTTON_RIGHT)
							btn_nxt[iepq_pkg::BTN_RIGHT] = ev_nz;
						else if (ev_code == iepq_pkg::BUTTON_MIDDLE)
							btn_nxt[iepq_pkg::BTN_MIDDLE] = ev_nz;
					end else if (ev_type == iepq_pkg::EVT_SYNC &&
						ev_code == iepq_pkg::SYNC_REPORT) begin
						ptr_push = (ptr_tail_inc != ptr_head_q);
					end
				end
				iepq_pkg::ACT_POP_KEY: begin
					key_pop = (key_head_q != key_tail_q);
					if (key_pop)
						kind_nxt = iepq_pkg::RES_KEY;
				end
				iepq_pkg::ACT_POP_PTR: begin
					ptr_pop = (ptr_head_q != ptr_tail_q);
					if (ptr_pop)
						kind_nxt = iepq_pkg::RES_PTR;
				end
				default: begin
					kind_nxt = iepq_pkg::RES_NONE;
				end
			endcase
		end
		key_tail_nxt = key_push ? key_tail_inc : key_tail_q;
		key_head_nxt = key_pop  ? key_head_inc : key_head_q;
		ptr_tail_nxt = ptr_push ? ptr_tail_inc : ptr_tail_q;
		ptr_head_nxt = ptr_pop  ? ptr_head_inc : ptr_head_q;
		pending_nxt  = (key_head_nxt != key_tail_nxt) || (ptr_head_nxt != ptr_tail_nxt);
	end

	// Pointers and latched pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_head_q    <= '0;
			key_tail_q    <= '0;
			ptr_head_q    <= '0;
			ptr_tail_q    <= '0;
			latched_x_q   <= '0;
			latched_y_q   <= '0;
			latched_btn_q <= '0;
		end else begin
			key_head_q    <= key_head_nxt;
			key_tail_q    <= key_tail_nxt;
			ptr_head_q    <= ptr_head_nxt;
			ptr_tail_q    <= ptr_tail_nxt;
			latched_btn_q <= btn_nxt;
			if (set_x)
				latched_x_q <= ev_value;
			if (set_y)
				latched_y_q <= ev_value;
		end
	end

	// Key ring: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (key_push)
			key_mem[key_tail_q] <= {ev_nz, ev_code[8:0]};
		if (key_pop)
			key_rd_q <= key_mem[key_head_q];
	end

	// Pointer ring: buttons, Y, X
	always_ff @(posedge clk) begin
		if (ptr_push)
			ptr_mem[ptr_tail_q] <= {latched_btn_q, latched_y_q, latched_x_q};
		if (ptr_pop)
			ptr_rd_q <= ptr_mem[ptr_head_q];
	end

	// Stage 1 control, waits for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1    <= kind_nxt;
			pending_s1 <= pending_nxt;
		end
	end

	// Result assembly from the read data
	always_comb begin
		res_nxt         = '0;
		res_nxt.pending = pending_s1;
		case (kind_s1)
			iepq_pkg::RES_KEY: begin
				res_nxt.key_code    = key_rd_q[8:0];
				res_nxt.key_pressed = key_rd_q[9];
			end
			iepq_pkg::RES_PTR: begin
				res_nxt.ptr_x       = ptr_rd_q[31:0];
				res_nxt.ptr_y       = ptr_rd_q[63:32];
				res_nxt.left_down   = ptr_rd_q[64 + iepq_pkg::BTN_LEFT];
				res_nxt.right_down  = ptr_rd_q[64 + iepq_pkg::BTN_RIGHT];
				res_nxt.middle_down = ptr_rd_q[64 + iepq_pkg::BTN_MIDDLE];
			end
			default: begin
				res_nxt.key_code = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			out_res_q  <= res_nxt;
			out_vres_q <= (kind_s1 != iepq_pkg::RES_NONE);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(iepq_pkg::OUT_DATA_W - iepq_pkg::RES_W){1'b0}}, out_res_q};
	assign m_axis_tuser  = out_vres_q;

endmodule

// ===== rtl/iepq_checker.sv =====
// ----------------------------------------------------------------------------
// iepq_checker
// Port-level checks of the input event report queue.
// ----------------------------------------------------------------------------
`include "input_event_report_queue_macros.svh"

module iepq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [iepq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [iepq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	logic stalled;

	assign stalled = m_axis_tvalid && !m_axis_tready;

	// A held result keeps its contents
	`IEPQ_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// Input is only held back by a waiting result
	`IEPQ_ASSERT_NOW(a_stall_cause, !s_axis_tready, stalled, "input stalled with no result waiting")

	// Non-pop results and empty pops carry only the pending flag
	`IEPQ_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[iepq_pkg::RES_W-2:0] == '0, "invalid result carries data")

	// Padding above the result word stays zero
	`IEPQ_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[iepq_pkg::OUT_DATA_W-1:iepq_pkg::RES_W] == '0, "nonzero padding in result")

endmodule

bind input_event_report_queue iepq_checker u_iepq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the input event report queue.
// ----------------------------------------------------------------------------
// A short table of directed items covers the empty rings, the field extremes,
// every action and the ignored events. Random traffic follows in blocks that
// fill, drain or mix the two rings, so both rings overflow and run empty many
// times. A predictor keeps its own rings and latched pointer state and checks
// every result field against the oldest expectation. Idling runs in three
// phases, with one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iepq_pkg::*;

	localparam int KEY_SLOTS   = KEY_DEPTH_DEF;
	localparam int PTR_SLOTS   = PTR_DEPTH_DEF;
	localparam int EVENT_ITEMS = 1800;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 8;
	localparam int PRINT_LIMIT = 40;

	// Traffic shape of one block of random items
	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} traffic_mode_t;

	// Expected outcome of one item: the tuser flag and the data word
	typedef struct {
		bit      valid;
		result_t res;
	} report_t;

	// Directed row: stimulus, then the typed-in result where typed is set
	typedef struct {
		action_t     act;
		logic [15:0] typ;
		logic [15:0] code;
		logic [31:0] val;
		bit          typed;
		bit          e_valid;
		logic [8:0]  e_code;
		logic        e_pressed;
		logic [31:0] e_x;
		logic [31:0] e_y;
		logic [2:0]  e_btn;
		logic        e_pending;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	input_event_report_queue u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Predictor state
	logic [9:0]  key_store [KEY_SLOTS];
	int          key_rd;
	int          key_wr;
	logic [63:0] ptr_xy_store [PTR_SLOTS];
	logic [2:0]  ptr_btn_store [PTR_SLOTS];
	int          ptr_rd;
	int          ptr_wr;
	logic [31:0] latch_x;
	logic [31:0] latch_y;
	logic [2:0]  latch_btn;

	report_t expected_reports [$];

	// Bookkeeping
	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  key_drops;
	int  ptr_drops;
	int  empty_pops;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_left;
	bit  hold_request;

	report_t want;
	result_t seen;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("FAIL input_event_report_queue");
		$finish;
	end

	// One item through the queue: updates the predictor and returns the result
	function automatic report_t queue_step(input action_t act, input logic [15:0] typ,
			input logic [15:0] code, input logic [31:0] val, output bit counted);
		report_t r;
		int      nxt;
		r.valid = 1'b0;
		r.res   = '0;
		counted = 1'b1;
		case (act)
			ACT_KEY_EVT: begin
				if (typ == EVT_KEY && code < BUTTON_LEFT) begin
					nxt = (key_wr + 1) % KEY_SLOTS;
					if (nxt == key_rd) begin
						key_drops++;
					end else begin
						key_store[key_wr] = {val != 32'd0, code[8:0]};
						key_wr = nxt;
					end
				end else begin
					counted = 1'b0;
				end
			end
			ACT_TABLET_EVT: begin
				if (typ == EVT_ABS && code == AXIS_X) begin
					latch_x = val;
				end else if (typ == EVT_ABS && code == AXIS_Y) begin
					latch_y = val;
				end else if (typ == EVT_KEY && code == BUTTON_LEFT) begin
					latch_btn[BTN_LEFT] = (val != 32'd0);
				end else if (typ == EVT_KEY && code == BUTTON_RIGHT) begin
					latch_btn[BTN_RIGHT] = (val != 32'd0);
				end else if (typ == EVT_KEY && code == BUTTON_MIDDLE) begin
					latch_btn[BTN_MIDDLE] = (val != 32'd0);
				end else if (typ == EVT_SYNC && code == SYNC_REPORT) begin
					nxt = (ptr_wr + 1) % PTR_SLOTS;
					if (nxt == ptr_rd) begin
						ptr_drops++;
					end else begin
						ptr_xy_store[ptr_wr]  = {latch_y, latch_x};
						ptr_btn_store[ptr_wr] = latch_btn;
						ptr_wr = nxt;
					end
				end else begin
					counted = 1'b0;
				end
			end
			ACT_POP_KEY: begin
				if (key_rd != key_wr) begin
					r.valid            = 1'b1;
					r.res.key_code    = key_store[key_rd][8:0];
					r.res.key_pressed = key_store[key_rd][9];
					key_rd = (key_rd + 1) % KEY_SLOTS;
				end else begin
					empty_pops++;
				end
			end
			default: begin
				if (ptr_rd != ptr_wr) begin
					r.valid            = 1'b1;
					r.res.ptr_x       = ptr_xy_store[ptr_rd][31:0];
					r.res.ptr_y       = ptr_xy_store[ptr_rd][63:32];
					r.res.left_down   = ptr_btn_store[ptr_rd][BTN_LEFT];
					r.res.right_down  = ptr_btn_store[ptr_rd][BTN_RIGHT];
					r.res.middle_down = ptr_btn_store[ptr_rd][BTN_MIDDLE];
					ptr_rd = (ptr_rd + 1) % PTR_SLOTS;
				end else begin
					empty_pops++;
				end
			end
		endcase
		r.res.pending = (key_rd != key_wr) || (ptr_rd != ptr_wr);
		return r;
	endfunction

	// Event value with zero and all-ones weighted up
	function automatic logic [31:0] rand_value();
		case ($urandom_range(9))
			0, 1:    return 32'd0;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] seen_v,
			input logic [31:0] want_v);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: result %0d, %s = 0x%0h, expected 0x%0h",
				$realtime, results_seen, what, seen_v, want_v);
	endtask

	// Offer one item, with random gaps, and log its expected result on accept
	task automatic send_item(input action_t act, input logic [15:0] typ,
			input logic [15:0] code, input logic [31:0] val, input bit typed,
			input report_t typed_rep, output bit counted);
		report_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, code, typ};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		predicted = queue_step(act, typ, code, val, counted);
		expected_reports.push_back(typed ? typed_rep : predicted);
		items_sent++;
	endtask

	// Drop valid and hold off until every result is back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	// Output side: random stalls plus one long hold on request
	initial begin
		bit hold_done;
		m_axis_tready = 1'b0;
		hold_left     = 0;
		hold_done     = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
			end else begin
				want = expected_reports.pop_front();
				seen = m_axis_tdata[RES_W-1:0];
				if (m_axis_tuser[0] !== want.valid)
					report_mismatch("valid_res", 32'(m_axis_tuser[0]), 32'(want.valid));
				if (seen.key_code !== want.res.key_code)
					report_mismatch("key_code", 32'(seen.key_code), 32'(want.res.key_code));
				if (seen.key_pressed !== want.res.key_pressed)
					report_mismatch("key_pressed", 32'(seen.key_pressed),
						32'(want.res.key_pressed));
				if (seen.ptr_x !== want.res.ptr_x)
					report_mismatch("ptr_x", seen.ptr_x, want.res.ptr_x);
				if (seen.ptr_y !== want.res.ptr_y)
					report_mismatch("ptr_y", seen.ptr_y, want.res.ptr_y);
				if (seen.left_down !== want.res.left_down)
					report_mismatch("left_down", 32'(seen.left_down),
						32'(want.res.left_down));
				if (seen.right_down !== want.res.right_down)
					report_mismatch("right_down", 32'(seen.right_down),
						32'(want.res.right_down));
				if (seen.middle_down !== want.res.middle_down)
					report_mismatch("middle_down", 32'(seen.middle_down),
						32'(want.res.middle_down));
				if (seen.pending !== want.res.pending)
					report_mismatch("pending", 32'(seen.pending), 32'(want.res.pending));
				if (m_axis_tdata[OUT_DATA_W-1:RES_W] !== '0)
					report_mismatch("pad bits", 32'(m_axis_tdata[OUT_DATA_W-1:RES_W]), '0);
			end
			results_seen++;
		end
	end

	// Stimulus
	initial begin
		stim_row_t     dir_table [25];
		report_t       typed_rep;
		bit            counted;
		traffic_mode_t mode;
		int            block_left;
		int            effective;
		int            phase;
		int            pick;
		int            pop_pct;
		action_t       act;
		logic [15:0]   typ;
		logic [15:0]   code;
		logic [31:0]   val;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_KEY_EVT;
		send_idle_pct = 14;
		recv_idle_pct = 81;
		hold_request  = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		results_seen  = 0;
		key_drops     = 0;
		ptr_drops     = 0;
		empty_pops    = 0;
		key_rd        = 0;
		key_wr        = 0;
		ptr_rd        = 0;
		ptr_wr        = 0;
		latch_x       = '0;
		latch_y       = '0;
		latch_btn     = '0;

		// act, type, code, value, typed, then valid, code, pressed, x, y, buttons, pending
		dir_table = '{
			// pops of both rings straight after reset
			'{ACT_POP_KEY, EVT_SYNC, '0, '0, 1'b1, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_POP_PTR, EVT_SYNC, '0, '0, 1'b1, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			// key codes at both ends, then ignored keyboard events
			'{ACT_KEY_EVT, EVT_KEY, '0, '0, 1'b1, 1'b0, '0, 1'b0, '0, '0, '0, 1'b1},
			'{ACT_KEY_EVT, EVT_KEY, 16'd271, '1, 1'b1, 1'b0, '0, 1'b0, '0, '0, '0, 1'b1},
			'{ACT_KEY_EVT, EVT_KEY, BUTTON_LEFT, 32'd1, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0,
				1'b0},
			'{ACT_KEY_EVT, EVT_SYNC, 16'd5, 32'd1, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_KEY_EVT, '1, '1, '1, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_POP_KEY, '1, '1, '1, 1'b1, 1'b1, '0, 1'b0, '0, '0, '0, 1'b1},
			'{ACT_POP_KEY, '0, '0, '0, 1'b1, 1'b1, 9'd271, 1'b1, '0, '0, '0, 1'b0},
			'{ACT_POP_KEY, '0, '0, '0, 1'b1, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			// latch pointer state, with ignored axis and button codes
			'{ACT_TABLET_EVT, EVT_ABS, AXIS_X, '1, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_TABLET_EVT, EVT_ABS, AXIS_Y, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, '0,
				'0, '0, 1'b0},
			'{ACT_TABLET_EVT, EVT_ABS, 16'd2, 32'd5, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0,
				1'b0},
			'{ACT_TABLET_EVT, EVT_KEY, BUTTON_LEFT, 32'd1, 1'b0, 1'b0, '0, 1'b0, '0, '0,
				'0, 1'b0},
			'{ACT_TABLET_EVT, EVT_KEY, BUTTON_RIGHT, 32'h100, 1'b0, 1'b0, '0, 1'b0, '0,
				'0, '0, 1'b0},
			'{ACT_TABLET_EVT, EVT_KEY, BUTTON_MIDDLE, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0,
				'0, '0, '0, 1'b0},
			'{ACT_TABLET_EVT, EVT_KEY, 16'd275, 32'd1, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0,
				1'b0},
			// snapshot, then a release that must not reach it
			'{ACT_TABLET_EVT, EVT_SYNC, SYNC_REPORT, '1, 1'b1, 1'b0, '0, 1'b0, '0, '0,
				'0, 1'b1},
			'{ACT_TABLET_EVT, EVT_KEY, BUTTON_RIGHT, '0, 1'b0, 1'b0, '0, 1'b0, '0, '0,
				'0, 1'b0},
			'{ACT_TABLET_EVT, EVT_SYNC, 16'd1, '0, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_TABLET_EVT, 16'd2, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_POP_PTR, '0, '0, '0, 1'b1, 1'b1, '0, 1'b0, '1, 32'h8000_0000, 3'b111,
				1'b0},
			'{ACT_TABLET_EVT, EVT_SYNC, SYNC_REPORT, '0, 1'b0, 1'b0, '0, 1'b0, '0, '0,
				'0, 1'b0},
			'{ACT_POP_PTR, '1, '1, '1, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0},
			'{ACT_TABLET_EVT, '1, '1, '0, 1'b0, 1'b0, '0, 1'b0, '0, '0, '0, 1'b0}
		};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed table
		foreach (dir_table[i]) begin
			typed_rep.valid           = dir_table[i].e_valid;
			typed_rep.res             = '0;
			typed_rep.res.key_code    = dir_table[i].e_code;
			typed_rep.res.key_pressed = dir_table[i].e_pressed;
			typed_rep.res.ptr_x       = dir_table[i].e_x;
			typed_rep.res.ptr_y       = dir_table[i].e_y;
			typed_rep.res.left_down   = dir_table[i].e_btn[BTN_LEFT];
			typed_rep.res.right_down  = dir_table[i].e_btn[BTN_RIGHT];
			typed_rep.res.middle_down = dir_table[i].e_btn[BTN_MIDDLE];
			typed_rep.res.pending     = dir_table[i].e_pending;
			send_item(dir_table[i].act, dir_table[i].typ, dir_table[i].code,
				dir_table[i].val, dir_table[i].typed, typed_rep, counted);
		end

		// Random traffic in fill, drain and mixed blocks
		effective  = 0;
		block_left = 0;
		phase      = 0;
		mode       = MODE_MIX;
		while (effective < EVENT_ITEMS) begin
			if (phase == 0 && effective >= EVENT_ITEMS / 3) begin
				wait_drained();
				phase         = 1;
				send_idle_pct = 81;
				recv_idle_pct = 14;
			end else if (phase == 1 && effective >= 2 * EVENT_ITEMS / 3) begin
				wait_drained();
				phase         = 2;
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_request  = 1'b1;
			end
			if (block_left == 0) begin
				mode       = traffic_mode_t'($urandom_range(2));
				block_left = (mode == MODE_FILL) ? $urandom_range(120, 200)
					: $urandom_range(30, 90);
			end
			block_left--;
			pop_pct = (mode == MODE_FILL) ? 5 : (mode == MODE_DRAIN) ? 80 : 35;

			typ  = 16'($urandom);
			code = 16'($urandom);
			val  = rand_value();
			if ($urandom_range(99) < pop_pct) begin
				act = $urandom_range(1) ? ACT_POP_KEY : ACT_POP_PTR;
			end else if ($urandom_range(1)) begin
				// keyboard: mostly valid key codes, some out of range or odd types
				act  = ACT_KEY_EVT;
				pick = $urandom_range(99);
				if (pick < 90) begin
					typ  = EVT_KEY;
					code = 16'($urandom_range(271));
				end else if (pick < 95) begin
					typ  = EVT_KEY;
					code = 16'($urandom_range(272, 65535));
				end
			end else begin
				// tablet: axis, buttons and sync reports, some noise
				act  = ACT_TABLET_EVT;
				pick = $urandom_range(99);
				if (pick < 30) begin
					typ  = EVT_SYNC;
					code = SYNC_REPORT;
				end else if (pick < 55) begin
					typ  = EVT_ABS;
					code = $urandom_range(1) ? AXIS_Y : AXIS_X;
					val  = $urandom;
				end else if (pick < 85) begin
					typ  = EVT_KEY;
					code = BUTTON_LEFT + 16'($urandom_range(2));
				end else begin
					typ = 16'($urandom_range(3));
					if ($urandom_range(1))
						code = 16'($urandom_range(270, 276));
					else if ($urandom_range(1))
						code = 16'($urandom_range(3));
				end
			end
			send_item(act, typ, code, val, 1'b0, typed_rep, counted);
			if (counted)
				effective++;
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d items (%0d directed), checked %0d results, %0d empty-ring pops.",
			items_sent, $size(dir_table), results_seen, empty_pops);
		$display("Full-ring drops: %0d key, %0d pointer; one %0d-cycle output stall.",
			key_drops, ptr_drops, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("PASS input_event_report_queue");
		end else begin
			$display("FAIL input_event_report_queue");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/iepq_pkg.sv
rtl/input_event_report_queue.sv
rtl/iepq_checker.sv
verif/tb.sv
